// ----- hdl/assert_macros.svh -----
// assertion macros for the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gra_pkg.sv -----
// types and constants of the guillotine rectangle allocator
`timescale 1ns / 1ps
`default_nettype none

package gra_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int STATUS_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 1'b1;

    localparam logic [CFG_W-1:0] ATLAS_W_RST = 13'd1024;
    localparam logic [CFG_W-1:0] ATLAS_H_RST = 13'd1024;

    // command codes
    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

    typedef struct packed {
        logic             command;
        logic [DIM_W-1:0] sprite_width;
        logic [DIM_W-1:0] sprite_height;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
    } rsp_t;

    // scan unit status toward the sequencer
    typedef struct packed {
        logic found;
        logic busy;
    } scan_stat_t;

endpackage

`default_nettype wire

// ----- hdl/guillotine_rect_allocator_unit.sv -----
// top level of the guillotine rectangle allocator with best-area fit
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_t  (command, sprite size)
//  rsp      out        rsp_valid / rsp_ready  rsp_t  (status, pos_x, pos_y)
//  cfg      in         cfg_we                 cfg_index, cfg_data
//
// a clear item rewrites entry 0 with the atlas size; a place item reads every free entry
// through the scan unit and ends there with no fit or a full table; when placed it shifts
// the entries after the chosen slot b up by one, then writes the right piece at b and the
// bottom piece at b + 1; the one-read one-write port of the free table sets the pace
// after reset the init state writes entry 0 with the reset atlas size; no item is taken then
// a finished item waits in the rsp register; the next item is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module guillotine_rect_allocator_unit
    import gra_pkg::*;
#(
    parameter int MAX_FREE   = 64,
    parameter int COORD_BITS = 12
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire req_t                 req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rsp_t                      rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int IW = $clog2(MAX_FREE);
    localparam int CW = $clog2(MAX_FREE + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int EW = 4 * DW;
    localparam int XW = (DW > CFG_W) ? DW : CFG_W;
    localparam int DIM_MAX = 2 ** COORD_BITS;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SHIFT,
        S_FLUSH,
        S_WR_R,
        S_WR_B,
        S_RESULT
    } state_t;

    // atlas dimension saturated to the coordinate range
    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DW-1:0] r;
        if (XW'(v) > XW'(DIM_MAX))
        begin
            r = DW'(DIM_MAX);
        end
        else
        begin
            r = DW'(v);
        end
        return r;
    endfunction

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         ridx_reg, ridx_next;
    logic                  rvalid_reg, rvalid_next;
    logic                  swvalid_reg, swvalid_next;
    logic [DIM_W-1:0]      sw_reg, sw_next;
    logic [DIM_W-1:0]      sh_reg, sh_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [POS_W-1:0]      posx_reg, posx_next;
    logic [POS_W-1:0]      posy_reg, posy_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;
    logic [CFG_W-1:0]      atlas_w_reg;
    logic [CFG_W-1:0]      atlas_h_reg;

    // free table
    logic [EW-1:0]         mem [MAX_FREE];
    logic [EW-1:0]         mem_rdata_reg;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;

    logic                  req_fire;
    logic                  scan_start;
    scan_stat_t            scan_stat;
    logic [IW-1:0]         best_idx;
    logic [EW-1:0]         best_ent;
    logic [DW-1:0]         bx, by, bw, bh;
    logic [EW-1:0]         right_piece;
    logic [EW-1:0]         bottom_piece;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign scan_start = req_fire && (req.command == CMD_PLACE);

    // chosen entry split into right and bottom pieces
    assign bx = best_ent[4*DW-1:3*DW];
    assign by = best_ent[3*DW-1:2*DW];
    assign bw = best_ent[2*DW-1:DW];
    assign bh = best_ent[DW-1:0];

    assign right_piece  = {bx + DW'(sw_reg), by, bw - DW'(sw_reg), DW'(sh_reg)};
    assign bottom_piece = {bx, by + DW'(sh_reg), bw, bh - DW'(sh_reg)};

    gra_scan #(
        .MAX_FREE   (MAX_FREE),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (scan_start),
        .ent_valid     (rvalid_reg),
        .ent_idx       (ridx_reg),
        .ent           (mem_rdata_reg),
        .sprite_width  (sw_reg),
        .sprite_height (sh_reg),
        .stat          (scan_stat),
        .best_idx      (best_idx),
        .best_ent      (best_ent)
    );

    // write port arbitration; a pending shift write owns the port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        priority if (state_reg == S_INIT)
        begin
            mem_we    = 1'b1;
            mem_wdata = {DW'(0), DW'(0), clamp_dim(ATLAS_W_RST), clamp_dim(ATLAS_H_RST)};
        end
        else if (req_fire && (req.command == CMD_CLEAR))
        begin
            mem_we    = 1'b1;
            mem_wdata = {DW'(0), DW'(0), clamp_dim(atlas_w_reg), clamp_dim(atlas_h_reg)};
        end
        else if (swvalid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = ridx_reg + IW'(1);
            mem_wdata = mem_rdata_reg;
        end
        else if (state_reg == S_WR_R)
        begin
            mem_we    = 1'b1;
            mem_waddr = best_idx;
            mem_wdata = right_piece;
        end
        else if (state_reg == S_WR_B)
        begin
            mem_we    = 1'b1;
            mem_waddr = best_idx + IW'(1);
            mem_wdata = bottom_piece;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[idx_reg];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_w_reg <= ATLAS_W_RST;
            atlas_h_reg <= ATLAS_H_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ATLAS_W: atlas_w_reg <= cfg_data;
                CFG_ATLAS_H: atlas_h_reg <= cfg_data;
                default:     atlas_w_reg <= atlas_w_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ridx_next      = ridx_reg;
        rvalid_next    = 1'b0;
        swvalid_next   = 1'b0;
        sw_next        = sw_reg;
        sh_next        = sh_reg;
        status_next    = status_reg;
        posx_next      = posx_reg;
        posy_next      = posy_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                count_next = CW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    posx_next = '0;
                    posy_next = '0;
                    if (req.command == CMD_CLEAR)
                    begin
                        count_next  = CW'(1);
                        status_next = ST_CLEARED;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        sw_next    = req.sprite_width;
                        sh_next    = req.sprite_height;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // one read per cycle, entries 0 .. count-1
                rvalid_next = 1'b1;
                ridx_next   = idx_reg;
                if (CW'(idx_reg) + CW'(1) == count_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!rvalid_reg && !scan_stat.busy)
                begin
                    if (!scan_stat.found)
                    begin
                        status_next = ST_NOFIT;
                        state_next  = S_RESULT;
                    end
                    else if (count_reg == CW'(MAX_FREE))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_RESULT;
                    end
                    else if (CW'(best_idx) + CW'(1) < count_reg)
                    begin
                        idx_next   = IW'(count_reg - CW'(1));
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_WR_R;
                    end
                end
            end
            S_SHIFT:
            begin
                // move entries up from the top down; each write comes in the cycle after its read
                swvalid_next = 1'b1;
                ridx_next    = idx_reg;
                if (idx_reg == best_idx + IW'(1))
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg - IW'(1);
                end
            end
            S_FLUSH:
            begin
                state_next = S_WR_R;
            end
            S_WR_R:
            begin
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                count_next  = count_reg + CW'(1);
                status_next = ST_PLACED;
                posx_next   = POS_W'(bx[COORD_BITS-1:0]);
                posy_next   = POS_W'(by[COORD_BITS-1:0]);
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status = status_reg;
                    rsp_next.pos_x  = posx_reg;
                    rsp_next.pos_y  = posy_reg;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= CW'(1);
            idx_reg       <= '0;
            rvalid_reg    <= 1'b0;
            swvalid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rvalid_reg    <= rvalid_next;
            swvalid_reg   <= swvalid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ridx_reg   <= ridx_next;
        sw_reg     <= sw_next;
        sh_reg     <= sh_next;
        status_reg <= status_next;
        posx_reg   <= posx_next;
        posy_reg   <= posy_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // one item in work at a time
    `GRA_ASSERT_NEXT(a_one_item, req_fire, !req_ready, "item taken while busy")
    // table grows by exactly one entry per placement
    `GRA_ASSERT_NEXT(a_count_inc, state_reg == S_WR_B, count_reg == $past(count_reg) + CW'(1), "free count did not grow by one")
    // shift write never lands on the slot being read
    `GRA_ASSERT_SAME(a_shift_sep, swvalid_reg && (state_reg == S_SHIFT), mem_waddr != idx_reg, "shift write hits read slot")

endmodule

`default_nettype wire

// ----- hdl/gra_scan.sv -----
// best-area-fit scan unit: two-stage pipeline over table entries
`timescale 1ns / 1ps
`default_nettype none

module gra_scan
    import gra_pkg::*;
#(
    parameter int MAX_FREE   = 64,
    parameter int COORD_BITS = 12
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            ent_valid,
    input  wire logic [$clog2(MAX_FREE)-1:0]     ent_idx,
    input  wire logic [4*(COORD_BITS+1)-1:0]     ent,
    input  wire logic [DIM_W-1:0]                sprite_width,
    input  wire logic [DIM_W-1:0]                sprite_height,
    output scan_stat_t                           stat,
    output logic      [$clog2(MAX_FREE)-1:0]     best_idx,
    output logic      [4*(COORD_BITS+1)-1:0]     best_ent
);

    localparam int IW = $clog2(MAX_FREE);
    localparam int DW = COORD_BITS + 1;
    localparam int EW = 4 * DW;
    localparam int XW = (DW > DIM_W) ? DW : DIM_W;
    localparam int AW = 2 * DW;

    logic [DW-1:0] ent_w;
    logic [DW-1:0] ent_h;
    logic          fit;

    logic          s1_valid_reg;
    logic          s1_fit_reg;
    logic [AW-1:0] s1_area_reg;
    logic [IW-1:0] s1_idx_reg;
    logic [EW-1:0] s1_ent_reg;

    logic          found_reg;
    logic [AW-1:0] best_area_reg;
    logic [IW-1:0] best_idx_reg;
    logic [EW-1:0] best_ent_reg;
    logic          take;

    // entry layout: {x, y, w, h}
    assign ent_w = ent[2*DW-1:DW];
    assign ent_h = ent[DW-1:0];
    assign fit   = (XW'(sprite_width) <= XW'(ent_w)) && (XW'(sprite_height) <= XW'(ent_h));

    // strict less keeps the earliest entry on equal area
    assign take = s1_valid_reg && s1_fit_reg && (!found_reg || (s1_area_reg < best_area_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ent_valid;
            if (start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fit_reg  <= fit;
        s1_area_reg <= AW'(ent_w) * AW'(ent_h);
        s1_idx_reg  <= ent_idx;
        s1_ent_reg  <= ent;
        if (take)
        begin
            best_area_reg <= s1_area_reg;
            best_idx_reg  <= s1_idx_reg;
            best_ent_reg  <= s1_ent_reg;
        end
    end

    assign stat.found = found_reg;
    assign stat.busy  = s1_valid_reg;
    assign best_idx   = best_idx_reg;
    assign best_ent   = best_ent_reg;

endmodule

`default_nettype wire

// ----- sim/guillotine_rect_allocator_unit_tb.sv -----
// testbench of the guillotine rectangle allocator: directed table, random items, predictor check
`timescale 1ns / 1ps

module guillotine_rect_allocator_unit_tb
    import gra_pkg::*;
();

    localparam int SLOTS    = 64;
    localparam int COORD    = 12;
    localparam int DIM_LIM  = 1 << COORD;
    // pause after the last result before a register write
    localparam int CFG_GAP  = 4;
    // worst place item: full scan plus shift of the whole table
    localparam int DRAIN_GAP = 2 * SLOTS + 8;

    // directed table rows: an item, or a register write (a holds the index, b the value)
    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic                cmd;
        logic [DIM_W-1:0]    a;
        logic [DIM_W-1:0]    b;
        bit                  pinned;   // expected result typed in the row
        logic [STATUS_W-1:0] st;
        logic [POS_W-1:0]    px;
        logic [POS_W-1:0]    py;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // idle chance per cycle, in percent, for each side
    int unsigned req_idle_pct = 0;
    int unsigned rsp_idle_pct = 0;

    // predictor state: free rectangle table and atlas registers
    int unsigned      free_x [SLOTS];
    int unsigned      free_y [SLOTS];
    int unsigned      free_w [SLOTS];
    int unsigned      free_h [SLOTS];
    int unsigned      free_n;
    logic [CFG_W-1:0] atlas_w_reg;
    logic [CFG_W-1:0] atlas_h_reg;

    rsp_t        expected_rsp [$];
    int unsigned n_mismatch = 0;
    dir_row_t    dir_rows [26];

    guillotine_rect_allocator_unit #(
        .MAX_FREE   (SLOTS),
        .COORD_BITS (COORD)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // atlas registers above the coordinate span saturate
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
        return (v > DIM_LIM) ? DIM_LIM : int'(v);
    endfunction

    // table back to one free rectangle spanning the atlas
    function automatic void rebuild_free_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            free_x[i] = 0;
            free_y[i] = 0;
            free_w[i] = 0;
            free_h[i] = 0;
        end
        free_w[0] = clamp_dim(atlas_w_reg);
        free_h[0] = clamp_dim(atlas_h_reg);
        free_n    = 1;
    endfunction

    // best-area placement of one item, updating the predicted table
    function automatic rsp_t alloc_predict(input req_t item);
        rsp_t        o;
        bit          found;
        int unsigned best, best_area, area, sw, sh, ex, ey, ew, eh;
        o         = '0;
        found     = 1'b0;
        best      = 0;
        best_area = 0;
        if (item.command == CMD_CLEAR)
        begin
            rebuild_free_table();
            o.status = ST_CLEARED;
            return o;
        end
        sw = item.sprite_width;
        sh = item.sprite_height;
        // smallest fitting area, earliest entry on a tie
        for (int i = 0; i < free_n; i++)
        begin
            if (sw <= free_w[i] && sh <= free_h[i])
            begin
                area = free_w[i] * free_h[i];
                if (!found || area < best_area)
                begin
                    found     = 1'b1;
                    best      = i;
                    best_area = area;
                end
            end
        end
        if (!found)
        begin
            o.status = ST_NOFIT;
            return o;
        end
        if (free_n >= SLOTS)
        begin
            o.status = ST_FULL;
            return o;
        end
        ex = free_x[best];
        ey = free_y[best];
        ew = free_w[best];
        eh = free_h[best];
        // open a slot right after the chosen entry
        for (int j = free_n; j > best + 1; j--)
        begin
            free_x[j] = free_x[j-1];
            free_y[j] = free_y[j-1];
            free_w[j] = free_w[j-1];
            free_h[j] = free_h[j-1];
        end
        // piece right of the sprite replaces the entry
        free_x[best] = ex + sw;
        free_y[best] = ey;
        free_w[best] = ew - sw;
        free_h[best] = sh;
        // piece below the sprite goes right after
        free_x[best+1] = ex;
        free_y[best+1] = ey + sh;
        free_w[best+1] = ew;
        free_h[best+1] = eh - sh;
        free_n++;
        o.status = ST_PLACED;
        o.pos_x  = ex[POS_W-1:0];   // far-edge coordinate wraps
        o.pos_y  = ey[POS_W-1:0];
        return o;
    endfunction

    // random item: mostly small fitting sprites, some noise, rare clears
    function automatic req_t random_item();
        req_t        r;
        int unsigned p, lim_w, lim_h;
        p               = $urandom_range(99);
        lim_w           = clamp_dim(atlas_w_reg) / 6 + 1;
        lim_h           = clamp_dim(atlas_h_reg) / 6 + 1;
        r.command       = CMD_PLACE;
        r.sprite_width  = DIM_W'($urandom_range(8191));
        r.sprite_height = DIM_W'($urandom_range(8191));
        if (p < 1)
        begin
            // sprite fields left as noise
            r.command = CMD_CLEAR;
        end
        else if (p < 9)
        begin
            // full field range, mostly no fit
        end
        else if (p < 19)
        begin
            // zero-size sprite in one or both dimensions
            r.sprite_width  = ($urandom_range(1) == 0) ? '0 : DIM_W'($urandom_range(lim_w));
            r.sprite_height = (r.sprite_width != 0 || $urandom_range(1) == 0)
                              ? '0 : DIM_W'($urandom_range(lim_h));
        end
        else
        begin
            r.sprite_width  = DIM_W'($urandom_range(lim_w, 1));
            r.sprite_height = DIM_W'($urandom_range(lim_h, 1));
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input req_t item, input bit pinned, input rsp_t pinned_rsp);
        rsp_t model_rsp;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        // predictor runs on every item so its table stays in step
        model_rsp = alloc_predict(item);
        expected_rsp.insert(expected_rsp.size(), pinned ? pinned_rsp : model_rsp);
        @(negedge clk);
    endtask

    // sender holds off until every expected result is in
    task automatic wait_results_done();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_rsp.size() != 0);
    endtask

    // register write while the block is idle
    task automatic write_atlas_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] val);
        wait_results_done();
        repeat (CFG_GAP) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_ATLAS_W)
            atlas_w_reg = val;
        else
            atlas_h_reg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // receiver stalls at random
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("result with no item waiting: status %0d pos_x %0d pos_y %0d",
                       rsp.status, rsp.pos_x, rsp.pos_y);
                n_mismatch++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    n_mismatch++;
                end
                if (rsp.pos_x !== want.pos_x)
                begin
                    $error("pos_x expected %0d actual %0d", want.pos_x, rsp.pos_x);
                    n_mismatch++;
                end
                if (rsp.pos_y !== want.pos_y)
                begin
                    $error("pos_y expected %0d actual %0d", want.pos_y, rsp.pos_y);
                    n_mismatch++;
                end
            end
        end
    end

    initial
    begin
        req_t item;
        rsp_t pin;
        logic [CFG_W-1:0] phase_w [3];
        logic [CFG_W-1:0] phase_h [3];

        // directed rows; the expected fields count only where pinned is set
        dir_rows = '{
            // whole reset atlas in one sprite, then nothing of size one is left
            '{ROW_ITEM, CMD_PLACE, 13'd1024, 13'd1024, 1'b1, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd1,    13'd1,    1'b1, ST_NOFIT,  12'd0, 12'd0},
            // zero-size sprite lands in a zero-size piece
            '{ROW_ITEM, CMD_PLACE, 13'd0,    13'd0,    1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_CLEAR, 13'd0,    13'd0,    1'b1, ST_CLEARED, 12'd0, 12'd0},
            // larger than the atlas, and the field maximum
            '{ROW_ITEM, CMD_PLACE, 13'd1025, 13'd1,    1'b1, ST_NOFIT,  12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd8191, 13'd8191, 1'b1, ST_NOFIT,  12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd100,  13'd50,   1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd50,   13'd100,  1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd100,  13'd50,   1'b0, ST_PLACED, 12'd0, 12'd0},
            // width register saturates to the coordinate span
            '{ROW_REG,  CMD_PLACE, CFG_ATLAS_W, 13'd8191, 1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_REG,  CMD_PLACE, CFG_ATLAS_H, 13'd4096, 1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_CLEAR, 13'd0,    13'd0,    1'b1, ST_CLEARED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd4096, 13'd4096, 1'b1, ST_PLACED, 12'd0, 12'd0},
            // pieces starting at the far edge, coordinate wraps
            '{ROW_ITEM, CMD_PLACE, 13'd0,    13'd0,    1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd0,    13'd5,    1'b0, ST_PLACED, 12'd0, 12'd0},
            // zero-size atlas
            '{ROW_REG,  CMD_PLACE, CFG_ATLAS_W, 13'd0, 1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_REG,  CMD_PLACE, CFG_ATLAS_H, 13'd0, 1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_CLEAR, 13'd0,    13'd0,    1'b1, ST_CLEARED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd0,    13'd0,    1'b1, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd1,    13'd0,    1'b1, ST_NOFIT,  12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd0,    13'd1,    1'b1, ST_NOFIT,  12'd0, 12'd0},
            // smallest real atlas; clear ignores its sprite fields
            '{ROW_REG,  CMD_PLACE, CFG_ATLAS_W, 13'd1, 1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_REG,  CMD_PLACE, CFG_ATLAS_H, 13'd1, 1'b0, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_CLEAR, 13'd8191, 13'd8191, 1'b1, ST_CLEARED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd1,    13'd1,    1'b1, ST_PLACED, 12'd0, 12'd0},
            '{ROW_ITEM, CMD_PLACE, 13'd1,    13'd1,    1'b1, ST_NOFIT,  12'd0, 12'd0}
        };

        // random phases: large atlas, random atlas, narrow atlas with saturating height
        phase_w[0] = 13'd4096;
        phase_h[0] = 13'd4096;
        phase_w[1] = CFG_W'($urandom_range(4096, 1));
        phase_h[1] = CFG_W'($urandom_range(4096, 1));
        phase_w[2] = 13'd200;
        phase_h[2] = 13'd5000;

        atlas_w_reg = ATLAS_W_RST;
        atlas_h_reg = ATLAS_H_RST;
        rebuild_free_table();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender 36, receiver 67 for the directed part and the first phase
        req_idle_pct = 36;
        rsp_idle_pct = 67;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_REG)
            begin
                write_atlas_reg(dir_rows[i].a[CFG_IDX_W-1:0], dir_rows[i].b);
            end
            else
            begin
                item.command       = dir_rows[i].cmd;
                item.sprite_width  = dir_rows[i].a;
                item.sprite_height = dir_rows[i].b;
                pin.status         = dir_rows[i].st;
                pin.pos_x          = dir_rows[i].px;
                pin.pos_y          = dir_rows[i].py;
                send_item(item, dir_rows[i].pinned, pin);
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            write_atlas_reg(CFG_ATLAS_W, phase_w[ph]);
            write_atlas_reg(CFG_ATLAS_H, phase_h[ph]);
            if (ph == 1)
            begin
                req_idle_pct = 67;
                rsp_idle_pct = 36;
            end
            else if (ph == 2)
            begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            // new atlas takes effect at a clear
            item = '0;
            item.command = CMD_CLEAR;
            send_item(item, 1'b0, '0);
            for (int n = 0; n < 134; n++)
            begin
                // now and then the sender waits for every result
                if ($urandom_range(99) < 2)
                    wait_results_done();
                send_item(random_item(), 1'b0, '0);
            end
        end

        wait_results_done();
        repeat (DRAIN_GAP) @(negedge clk);
        if (n_mismatch == 0 && expected_rsp.size() == 0)
            $display("guillotine_rect_allocator_unit_tb passed");
        else
            $display("guillotine_rect_allocator_unit_tb failed");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #2_000_000;
        $display("guillotine_rect_allocator_unit_tb failed");
        $finish;
    end

endmodule
